// File: src/spm_pkg.sv
`timescale 1ns / 1ps

package spm_pkg;

	// Sizes of the sample store and of the voice bank.
	localparam int SAMPLE_WORDS = 65536;
	localparam int VOICES = 32;
	localparam int VOICE_W = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int MEM_AW = $clog2(SAMPLE_WORDS);
	localparam int PAN_STEPS = 100;
	localparam logic [63:0] VOL_RATIO = 64'd4218396143;

	// Host command codes.
	typedef enum logic [1:0] {
		CMD_REG_WRITE = 2'd0,
		CMD_REG_READ  = 2'd1,
		CMD_MEM_WRITE = 2'd2,
		CMD_TICK      = 2'd3
	} cmd_code_t;

	// Voice key states.
	typedef enum logic [1:0] {
		KEY_OFF = 2'd0,
		KEY_ON  = 2'd1,
		KEY_REL = 2'd2
	} key_t;

	// Register offsets below the voice window.
	localparam logic [9:0] OFF_STATUS = 10'h000;
	localparam logic [9:0] OFF_VOICE_CTL = 10'h001;

	// Per-voice register indexes.
	localparam logic [4:0] VREG_START_HIGH = 5'h00;
	localparam logic [4:0] VREG_START_LOW  = 5'h01;
	localparam logic [4:0] VREG_FREQ       = 5'h02;
	localparam logic [4:0] VREG_END_LOW    = 5'h03;
	localparam logic [4:0] VREG_END_LOOP   = 5'h04;
	localparam logic [4:0] VREG_LOOP_LOW   = 5'h05;
	localparam logic [4:0] VREG_PAN        = 5'h06;
	localparam logic [4:0] VREG_VOL_TYPE   = 5'h08;
	localparam logic [4:0] VREG_FLAG       = 5'h0E;

	// Key control codes in bits 6..5 of a voice control write.
	localparam logic [1:0] KEYCTL_ON  = 2'b11;
	localparam logic [1:0] KEYCTL_REL = 2'b10;

	// Sample format codes in bits 15..14 of volume_type.
	localparam logic [1:0] FMT_WORD = 2'd0;
	localparam logic [1:0] FMT_LOW  = 2'd1;
	localparam logic [1:0] FMT_HIGH = 2'd2;

	localparam int FLAG_TIMBRE_BIT = 10;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SCALE,
		ST_PAN_L,
		ST_PAN_R,
		ST_OUT
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic               reg_write;
		logic               mem_write;
		logic               tick_clear;
		logic               fetch;
		logic               scale;
		logic               pan_l;
		logic               pan_r;
		logic               out_load;
		logic               out_tick;
		logic [VOICE_W-1:0] voice;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic voice_active;
	} dp_status_t;

	typedef logic [7:0] vol_rom_t [256];
	typedef logic [16:0] pan_rom_t [PAN_STEPS];

	// Volume table: 255 * 10^(-i/128), built by repeated truncated Q32 products.
	function automatic vol_rom_t build_vol_rom();
		vol_rom_t rom;
		logic [63:0] m;
		m = 64'd255 << 32;
		for (int i = 0; i < 256; i++) begin
			rom[i] = m[39:32];
			m = (((m >> 16) * VOL_RATIO) + (((m & 64'hFFFF) * VOL_RATIO) >> 16)) >> 16;
		end
		return rom;
	endfunction

	// Pan gains: floor(65536 * sqrt((100 - i) / 100)) by exact integer root.
	function automatic pan_rom_t build_pan_rom();
		pan_rom_t rom;
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		for (int i = 0; i < PAN_STEPS; i++) begin
			x = (64'(PAN_STEPS - i) << 32) / PAN_STEPS;
			r = 64'd0;
			b = 64'd1 << 62;
			while (b > x) b = b >> 2;
			while (b != 64'd0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			rom[i] = r[16:0];
		end
		return rom;
	endfunction

	localparam vol_rom_t VOL_ROM = build_vol_rom();
	localparam pan_rom_t PAN_ROM = build_pan_rom();

endpackage

// File: src/spm_if.sv
`timescale 1ns / 1ps

// Host request channel.
interface spm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [10:0] reg_offset;
	logic [15:0] write_data;
	logic [15:0] mem_address;

	modport source (output valid, command, reg_offset, write_data, mem_address, input ready);
	modport sink (input valid, command, reg_offset, write_data, mem_address, output ready);
endinterface

// Result channel.
interface spm_out_if;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic [15:0]        read_data;
	logic signed [19:0] left_out;
	logic signed [19:0] right_out;

	modport source (output valid, result_kind, read_data, left_out, right_out, input ready);
	modport sink (input valid, result_kind, read_data, left_out, right_out, output ready);
endinterface

// File: src/pcm_sample_voice_mixer_core.sv
`timescale 1ns / 1ps
// Register and memory writes take effect in the beat's cycle; a read result is registered
// and presented in the cycle after its beat is accepted.
// A tick sweeps the voices one at a time: a silent voice is skipped in the fetch state, and a
// sounding voice steps through fetch, scale, pan-left and pan-right, sharing one pan multiplier.
// Reset (arst_n low) clears all voice registers, status and key states at once;
// sample memory is not cleared and holds nothing meaningful until written.
module pcm_sample_voice_mixer_core (
	input  logic        clk,
	input  logic        arst_n,
	spm_in_if.sink      in_ch,
	spm_out_if.source   out_ch,
	input  logic        cfg_write_en,
	input  logic [16:0] cfg_write_data
);

	spm_pkg::ctrl_cmd_t  cmd;
	spm_pkg::dp_status_t status;

	// Sequencer.
	spm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_command (in_ch.command),
		.out_ready  (out_ch.ready),
		.status     (status),
		.in_ready   (in_ch.ready),
		.out_valid  (out_ch.valid),
		.cmd        (cmd)
	);

	// Register file, sample memory and mixing datapath.
	spm_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.reg_offset     (in_ch.reg_offset),
		.write_data     (in_ch.write_data),
		.mem_address    (in_ch.mem_address),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.result_kind    (out_ch.result_kind),
		.read_data      (out_ch.read_data),
		.left_out       (out_ch.left_out),
		.right_out      (out_ch.right_out)
	);

endmodule

// File: src/spm_datapath.sv
`timescale 1ns / 1ps

module spm_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  spm_pkg::ctrl_cmd_t     cmd,
	output spm_pkg::dp_status_t    status,
	input  logic [10:0]            reg_offset,
	input  logic [15:0]            write_data,
	input  logic [15:0]            mem_address,
	input  logic                   cfg_write_en,
	input  logic [16:0]            cfg_write_data,
	output logic                   result_kind,
	output logic [15:0]            read_data,
	output logic signed [19:0]     left_out,
	output logic signed [19:0]     right_out
);

	// Sample memory, no reset.
	logic [15:0] mem [spm_pkg::SAMPLE_WORDS];

	// Global registers.
	logic [15:0] status_q;
	logic [16:0] mem_words_q;

	// Voice bank.
	logic [15:0]       start_high_q [spm_pkg::VOICES];
	logic [15:0]       start_low_q [spm_pkg::VOICES];
	logic [15:0]       end_low_q [spm_pkg::VOICES];
	logic [15:0]       end_loop_q [spm_pkg::VOICES];
	logic [15:0]       loop_low_q [spm_pkg::VOICES];
	logic [15:0]       pan_q [spm_pkg::VOICES];
	logic [15:0]       vol_type_q [spm_pkg::VOICES];
	logic [15:0]       flag_q [spm_pkg::VOICES];
	logic [40:0]       pos_q [spm_pkg::VOICES];
	logic [22:0]       step_q [spm_pkg::VOICES];
	spm_pkg::key_t     key_q [spm_pkg::VOICES];

	// Pipeline registers for one voice.
	logic [15:0]        rd_s1;
	logic               in_range_s1;
	logic [40:0]        pos_sum_s1;
	logic signed [17:0] scaled_s2;
	logic signed [23:0] lsum_q;
	logic signed [23:0] rsum_q;

	// Decoded write targets.
	logic [4:0]                  reg_voice;
	logic [4:0]                  ctl_voice;
	logic                        reg_voice_ok;
	logic                        ctl_voice_ok;
	logic [spm_pkg::VOICE_W-1:0] rv;
	logic [spm_pkg::VOICE_W-1:0] cvw;
	logic [22:0]                 step_new;

	// Current voice view.
	logic [spm_pkg::VOICE_W-1:0] cv;
	logic [24:0]                 limit;
	logic [24:0]                 idx;
	logic [24:0]                 idx_next;
	logic [24:0]                 end_a;
	logic [23:0]                 loop_a;
	logic                        end_hit;
	logic [40:0]                 pos_adv;
	logic [15:0]                 w_fmt;
	logic [15:0]                 w_sgn;
	logic signed [24:0]          vol_prod;
	logic [7:0]                  pan_idx;
	logic [16:0]                 gain;
	logic signed [35:0]          pan_prod;
	logic signed [35:0]          pan_trunc;
	logic signed [23:0]          term;

	assign reg_voice = reg_offset[9:5];
	assign ctl_voice = write_data[4:0];
	assign reg_voice_ok = 32'(reg_voice) < spm_pkg::VOICES;
	assign ctl_voice_ok = 32'(ctl_voice) < spm_pkg::VOICES;
	assign rv = reg_voice[spm_pkg::VOICE_W-1:0];
	assign cvw = ctl_voice[spm_pkg::VOICE_W-1:0];
	assign step_new = 23'({10'd0, write_data[12:0]} << write_data[15:13]) << 2;

	assign cv = cmd.voice;
	assign limit = ({8'd0, mem_words_q} < 25'(spm_pkg::SAMPLE_WORDS)) ?
		{8'd0, mem_words_q} : 25'(spm_pkg::SAMPLE_WORDS);
	assign idx = pos_q[cv][40:16];

	// A voice sounds while keyed on, or released with the timbre flag set.
	assign status.voice_active = (key_q[cv] == spm_pkg::KEY_ON) ||
		((key_q[cv] == spm_pkg::KEY_REL) && flag_q[cv][spm_pkg::FLAG_TIMBRE_BIT]);

	// End test and loop wrap on the advanced position.
	always_comb begin
		idx_next = pos_sum_s1[40:16];
		end_a = {1'b0, end_loop_q[cv][7:0], end_low_q[cv]};
		loop_a = {end_loop_q[cv][15:8], loop_low_q[cv]};
		end_hit = (idx_next >= limit) || (idx_next > end_a);
		if (end_hit && (key_q[cv] == spm_pkg::KEY_ON)) begin
			pos_adv = {1'b0, pos_sum_s1[39:16] - loop_a, 16'd0};
		end else begin
			pos_adv = pos_sum_s1;
		end
	end

	// Format selection, sign conversion and volume scaling.
	always_comb begin
		case (vol_type_q[cv][15:14])
			spm_pkg::FMT_WORD: w_fmt = rd_s1;
			spm_pkg::FMT_LOW:  w_fmt = {rd_s1[7:0], 8'd0};
			spm_pkg::FMT_HIGH: w_fmt = {rd_s1[15:8], 8'd0};
			default:           w_fmt = 16'd0;
		endcase
		if (!in_range_s1) begin
			w_fmt = 16'd0;
		end
		w_sgn = w_fmt[15] ? (w_fmt ^ 16'h7FFF) : w_fmt;
		vol_prod = $signed(w_sgn) * $signed({1'b0, spm_pkg::VOL_ROM[vol_type_q[cv][7:0]]});
	end

	// Pan gain, shared multiplier, product truncated toward zero.
	always_comb begin
		pan_idx = cmd.pan_l ? pan_q[cv][15:8] : pan_q[cv][7:0];
		gain = (32'(pan_idx) < spm_pkg::PAN_STEPS) ?
			spm_pkg::PAN_ROM[pan_idx[6:0]] : 17'd0;
		pan_prod = scaled_s2 * $signed({1'b0, gain});
		pan_trunc = pan_prod[35] ? ((pan_prod + 36'sd65535) >>> 16) : (pan_prod >>> 16);
		term = pan_trunc[23:0];
	end

	// Sample memory write port and fetch read port.
	always_ff @(posedge clk) begin
		if (cmd.mem_write && (25'(mem_address) < 25'(spm_pkg::SAMPLE_WORDS))) begin
			mem[spm_pkg::MEM_AW'(mem_address)] <= write_data;
		end
		if (cmd.fetch) begin
			rd_s1 <= mem[idx[spm_pkg::MEM_AW-1:0]];
			in_range_s1 <= idx < limit;
			pos_sum_s1 <= pos_q[cv] + {18'd0, step_q[cv]};
		end
	end

	// Volume stage and mix accumulators.
	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			scaled_s2 <= vol_prod[23:6];
		end
		if (cmd.tick_clear) begin
			lsum_q <= '0;
			rsum_q <= '0;
		end else if (cmd.pan_l) begin
			lsum_q <= lsum_q + term;
		end else if (cmd.pan_r) begin
			rsum_q <= rsum_q + term;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_tick) begin
				result_kind <= 1'b1;
				read_data <= 16'd0;
				left_out <= lsum_q[22:3];
				right_out <= rsum_q[22:3];
			end else begin
				result_kind <= 1'b0;
				read_data <= (reg_offset == 11'(spm_pkg::OFF_STATUS)) ? status_q : 16'd0;
				left_out <= '0;
				right_out <= '0;
			end
		end
	end

	// Configuration and status word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_words_q <= 17'h10000;
			status_q <= '0;
		end else begin
			if (cfg_write_en) begin
				mem_words_q <= cfg_write_data;
			end
			if (cmd.reg_write && (reg_offset == 11'(spm_pkg::OFF_STATUS))) begin
				status_q <= write_data;
			end
		end
	end

	// Voice bank: host writes, key control and position advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < spm_pkg::VOICES; i++) begin
				start_high_q[i] <= '0;
				start_low_q[i] <= '0;
				end_low_q[i] <= '0;
				end_loop_q[i] <= '0;
				loop_low_q[i] <= '0;
				pan_q[i] <= '0;
				vol_type_q[i] <= '0;
				flag_q[i] <= '0;
				pos_q[i] <= '0;
				step_q[i] <= '0;
				key_q[i] <= spm_pkg::KEY_OFF;
			end
		end else begin
			if (cmd.reg_write && reg_offset[10] && reg_voice_ok) begin
				case (reg_offset[4:0])
					spm_pkg::VREG_START_HIGH: start_high_q[rv] <= write_data;
					spm_pkg::VREG_START_LOW:  start_low_q[rv] <= write_data;
					spm_pkg::VREG_FREQ:       step_q[rv] <= step_new;
					spm_pkg::VREG_END_LOW:    end_low_q[rv] <= write_data;
					spm_pkg::VREG_END_LOOP:   end_loop_q[rv] <= write_data;
					spm_pkg::VREG_LOOP_LOW:   loop_low_q[rv] <= write_data;
					spm_pkg::VREG_PAN:        pan_q[rv] <= write_data;
					spm_pkg::VREG_VOL_TYPE:   vol_type_q[rv] <= write_data;
					spm_pkg::VREG_FLAG:       flag_q[rv] <= write_data;
					default: ;
				endcase
			end
			if (cmd.reg_write && !reg_offset[10] &&
				(reg_offset[9:0] == spm_pkg::OFF_VOICE_CTL) && ctl_voice_ok) begin
				if (write_data[6:5] == spm_pkg::KEYCTL_ON) begin
					pos_q[cvw] <= {1'b0, start_high_q[cvw][15:8], start_low_q[cvw], 16'd0};
					key_q[cvw] <= spm_pkg::KEY_ON;
				end else if (write_data[6:5] == spm_pkg::KEYCTL_REL) begin
					key_q[cvw] <= spm_pkg::KEY_REL;
				end else begin
					key_q[cvw] <= spm_pkg::KEY_OFF;
				end
			end
			if (cmd.scale) begin
				pos_q[cv] <= pos_adv;
				if (end_hit && (key_q[cv] != spm_pkg::KEY_ON)) begin
					key_q[cv] <= spm_pkg::KEY_OFF;
				end
			end
		end
	end

endmodule

// File: src/spm_ctrl.sv
`timescale 1ns / 1ps

module spm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [1:0]            in_command,
	input  logic                  out_ready,
	input  spm_pkg::dp_status_t   status,
	output logic                  in_ready,
	output logic                  out_valid,
	output spm_pkg::ctrl_cmd_t    cmd
);

	spm_pkg::ctrl_state_t        state_q;
	spm_pkg::ctrl_state_t        state_d;
	logic [spm_pkg::VOICE_W-1:0] voice_q;
	logic [spm_pkg::VOICE_W-1:0] voice_d;
	logic                        out_valid_q;
	logic                        out_free;
	logic                        last_voice;
	logic                        in_accept;

	assign out_valid = out_valid_q;
	assign out_free = !out_valid_q || out_ready;
	assign last_voice = voice_q == spm_pkg::VOICE_W'(spm_pkg::VOICES - 1);
	assign in_accept = in_valid && in_ready;

	// State, voice counter and result-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spm_pkg::ST_IDLE;
			voice_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			voice_q <= voice_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		voice_d = voice_q;
		in_ready = 1'b0;
		cmd = '0;
		cmd.voice = voice_q;
		unique case (state_q)
			spm_pkg::ST_IDLE: begin
				in_ready = out_free;
				if (in_valid && out_free) begin
					unique case (in_command)
						spm_pkg::CMD_REG_WRITE: cmd.reg_write = 1'b1;
						spm_pkg::CMD_REG_READ:  cmd.out_load = 1'b1;
						spm_pkg::CMD_MEM_WRITE: cmd.mem_write = 1'b1;
						spm_pkg::CMD_TICK: begin
							cmd.tick_clear = 1'b1;
							voice_d = '0;
							state_d = spm_pkg::ST_FETCH;
						end
						default: ;
					endcase
				end
			end
			spm_pkg::ST_FETCH: begin
				if (status.voice_active) begin
					cmd.fetch = 1'b1;
					state_d = spm_pkg::ST_SCALE;
				end else if (last_voice) begin
					state_d = spm_pkg::ST_OUT;
				end else begin
					voice_d = voice_q + 1'b1;
				end
			end
			spm_pkg::ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d = spm_pkg::ST_PAN_L;
			end
			spm_pkg::ST_PAN_L: begin
				cmd.pan_l = 1'b1;
				state_d = spm_pkg::ST_PAN_R;
			end
			spm_pkg::ST_PAN_R: begin
				cmd.pan_r = 1'b1;
				if (last_voice) begin
					state_d = spm_pkg::ST_OUT;
				end else begin
					voice_d = voice_q + 1'b1;
					state_d = spm_pkg::ST_FETCH;
				end
			end
			spm_pkg::ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_tick = 1'b1;
					state_d = spm_pkg::ST_IDLE;
				end
			end
			default: state_d = spm_pkg::ST_IDLE;
		endcase
	end

`ifndef NO_ASSERTIONS
	// A tick starts the voice sweep at the first voice.
	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (in_command == spm_pkg::CMD_TICK)) |=>
		(state_q == spm_pkg::ST_FETCH && voice_q == '0))
		else $error("tick did not start the sweep at voice zero");

	// A new result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten while waiting");

	// The volume stage always follows a fetch of the same voice.
	a_scale_after_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spm_pkg::ST_SCALE) |->
		($past(state_q) == spm_pkg::ST_FETCH && $stable(voice_q)))
		else $error("volume stage without a fetch");
`endif

endmodule

// File: dv/spm_mixer_checker.sv
`timescale 1ns / 1ps

module spm_mixer_checker (
	input  logic        clk,
	input  logic        arst_n,
	spm_in_if           in_mon,
	spm_out_if          out_mon,
	input  logic        cfg_write_en,
	input  logic [16:0] cfg_write_data,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic        kind;
		logic [15:0] rdata;
		logic [19:0] left_mix;
		logic [19:0] right_mix;
	} mix_result_t;

	mix_result_t mix_expect_q[$];

	// Shadow copy of the mixer state.
	logic [15:0]     shadow_mem [spm_pkg::SAMPLE_WORDS];
	logic [16:0]     mem_limit;
	logic [15:0]     status_reg;
	logic [15:0]     start_hi [spm_pkg::VOICES];
	logic [15:0]     start_lo [spm_pkg::VOICES];
	logic [15:0]     end_lo [spm_pkg::VOICES];
	logic [15:0]     end_loop_hi [spm_pkg::VOICES];
	logic [15:0]     loop_lo [spm_pkg::VOICES];
	logic [15:0]     pan_reg [spm_pkg::VOICES];
	logic [15:0]     vol_fmt [spm_pkg::VOICES];
	logic [15:0]     flags [spm_pkg::VOICES];
	logic [63:0]     play_pos [spm_pkg::VOICES];
	logic [31:0]     pitch_step [spm_pkg::VOICES];
	spm_pkg::key_t   voice_key [spm_pkg::VOICES];

	logic [15:0] atten_tbl [256];
	logic [31:0] gain_tbl [spm_pkg::PAN_STEPS];

	// Build the attenuation and pan gain tables once and clear the shadow sample memory.
	initial begin
		logic [63:0] m;
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] t;
		m = 64'd255 << 32;
		for (int i = 0; i < 256; i++) begin
			atten_tbl[i] = m[47:32];
			m = (((m >> 16) * spm_pkg::VOL_RATIO) +
				(((m & 64'hFFFF) * spm_pkg::VOL_RATIO) >> 16)) >> 16;
		end
		for (int i = 0; i < spm_pkg::PAN_STEPS; i++) begin
			x = (64'(spm_pkg::PAN_STEPS - i) << 32) / spm_pkg::PAN_STEPS;
			r = 64'd0;
			for (int b = 17; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= x) begin
					r = t;
				end
			end
			gain_tbl[i] = r[31:0];
		end
		for (int a = 0; a < spm_pkg::SAMPLE_WORDS; a++) begin
			shadow_mem[a] = 16'h0000;
		end
	end

	function automatic longint gain_of(input logic [7:0] idx);
		return (idx < spm_pkg::PAN_STEPS) ? longint'(gain_tbl[idx]) : 64'sd0;
	endfunction

	// Q16 product truncated toward zero.
	function automatic longint trunc_q16(input longint v);
		return (v >= 0) ? (v >>> 16) : -((-v) >>> 16);
	endfunction

	task automatic write_register(input logic [10:0] off, input logic [15:0] d);
		logic [4:0] v;
		v = d[4:0];
		if (!off[10]) begin
			if (off[9:0] == spm_pkg::OFF_STATUS) begin
				status_reg = d;
			end else if (off[9:0] == spm_pkg::OFF_VOICE_CTL) begin
				if (d[6:5] == spm_pkg::KEYCTL_ON) begin
					play_pos[v] = {24'h0, start_hi[v][15:8], start_lo[v], 16'h0000};
					voice_key[v] = spm_pkg::KEY_ON;
				end else if (d[6:5] == spm_pkg::KEYCTL_REL) begin
					voice_key[v] = spm_pkg::KEY_REL;
				end else begin
					voice_key[v] = spm_pkg::KEY_OFF;
				end
			end
		end else begin
			v = off[9:5];
			case (off[4:0])
				spm_pkg::VREG_START_HIGH: start_hi[v] = d;
				spm_pkg::VREG_START_LOW:  start_lo[v] = d;
				spm_pkg::VREG_FREQ:       pitch_step[v] = ({19'h0, d[12:0]} << d[15:13]) * 4;
				spm_pkg::VREG_END_LOW:    end_lo[v] = d;
				spm_pkg::VREG_END_LOOP:   end_loop_hi[v] = d;
				spm_pkg::VREG_LOOP_LOW:   loop_lo[v] = d;
				spm_pkg::VREG_PAN:        pan_reg[v] = d;
				spm_pkg::VREG_VOL_TYPE:   vol_fmt[v] = d;
				spm_pkg::VREG_FLAG:       flags[v] = d;
				default: ;
			endcase
		end
	endtask

	// One output sample: mix every sounding voice, then advance it.
	task automatic mix_tick(output logic [19:0] left_o, output logic [19:0] right_o);
		longint lsum;
		longint rsum;
		longint s;
		longint scaled;
		longint shifted;
		logic [63:0] p;
		logic [63:0] idx;
		logic [63:0] end_a;
		logic [63:0] loop_a;
		logic [63:0] lim;
		logic [15:0] w;
		lsum = 0;
		rsum = 0;
		lim = (mem_limit < spm_pkg::SAMPLE_WORDS) ? 64'(mem_limit) : 64'(spm_pkg::SAMPLE_WORDS);
		for (int v = 0; v < spm_pkg::VOICES; v++) begin
			if (voice_key[v] == spm_pkg::KEY_ON ||
				(voice_key[v] == spm_pkg::KEY_REL && flags[v][spm_pkg::FLAG_TIMBRE_BIT])) begin
				p = play_pos[v];
				idx = p >> 16;
				end_a = {40'h0, end_loop_hi[v][7:0], end_lo[v]};
				loop_a = {40'h0, end_loop_hi[v][15:8], loop_lo[v]};
				w = (idx < lim) ? shadow_mem[idx[15:0]] : 16'h0000;
				case (vol_fmt[v][15:14])
					spm_pkg::FMT_WORD: ;
					spm_pkg::FMT_LOW:  w = {w[7:0], 8'h00};
					spm_pkg::FMT_HIGH: w = {w[15:8], 8'h00};
					default:           w = 16'h0000;
				endcase
				if (w[15]) begin
					w[14:0] = ~w[14:0];
				end
				s = longint'($signed(w));
				scaled = (s * longint'(atten_tbl[vol_fmt[v][7:0]])) >>> 6;
				lsum += trunc_q16(scaled * gain_of(pan_reg[v][15:8]));
				rsum += trunc_q16(scaled * gain_of(pan_reg[v][7:0]));
				p = p + 64'(pitch_step[v]);
				idx = p >> 16;
				if (idx >= lim || idx > end_a) begin
					if (voice_key[v] == spm_pkg::KEY_ON) begin
						p = (p - (loop_a << 16)) & 64'hFF_FFFF_0000;
					end else begin
						voice_key[v] = spm_pkg::KEY_OFF;
					end
				end
				play_pos[v] = p;
			end
		end
		shifted = lsum >>> 3;
		left_o = shifted[19:0];
		shifted = rsum >>> 3;
		right_o = shifted[19:0];
	endtask

	// Track every beat on both channels and the configuration port.
	always @(posedge clk or negedge arst_n) begin
		mix_result_t got;
		mix_result_t want;
		if (!arst_n) begin
			mix_expect_q.delete();
			mem_limit = 17'd65536;
			status_reg = 16'h0000;
			for (int v = 0; v < spm_pkg::VOICES; v++) begin
				start_hi[v] = 16'h0;
				start_lo[v] = 16'h0;
				end_lo[v] = 16'h0;
				end_loop_hi[v] = 16'h0;
				loop_lo[v] = 16'h0;
				pan_reg[v] = 16'h0;
				vol_fmt[v] = 16'h0;
				flags[v] = 16'h0;
				play_pos[v] = 64'h0;
				pitch_step[v] = 32'h0;
				voice_key[v] = spm_pkg::KEY_OFF;
			end
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_write_en) begin
				mem_limit = cfg_write_data;
			end
			if (in_mon.valid && in_mon.ready) begin
				want = '0;
				case (in_mon.command)
					spm_pkg::CMD_REG_WRITE: write_register(in_mon.reg_offset, in_mon.write_data);
					spm_pkg::CMD_REG_READ: begin
						want.rdata = (in_mon.reg_offset == 11'(spm_pkg::OFF_STATUS)) ?
							status_reg : 16'h0;
						mix_expect_q.push_back(want);
					end
					spm_pkg::CMD_MEM_WRITE: shadow_mem[in_mon.mem_address] = in_mon.write_data;
					default: begin
						want.kind = 1'b1;
						mix_tick(want.left_mix, want.right_mix);
						mix_expect_q.push_back(want);
					end
				endcase
			end
			if (out_mon.valid && out_mon.ready) begin
				got = {out_mon.result_kind, out_mon.read_data, out_mon.left_out, out_mon.right_out};
				if (mix_expect_q.size() == 0) begin
					$display("%0t: unexpected result beat kind=%0d read=%h left=%h right=%h",
						$time, got.kind, got.rdata, got.left_mix, got.right_mix);
					fail_count <= fail_count + 1;
				end else begin
					want = mix_expect_q.pop_front();
					if (got != want) begin
						$display("%0t: expected kind=%0d read=%h left=%h right=%h", $time,
							want.kind, want.rdata, want.left_mix, want.right_mix);
						$display("%0t:   actual kind=%0d read=%h left=%h right=%h", $time,
							got.kind, got.rdata, got.left_mix, got.right_mix);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= mix_expect_q.size();
		end
	end

endmodule

// File: dv/pcm_sample_voice_mixer_core_test.sv
`timescale 1ns / 1ps

module pcm_sample_voice_mixer_core_test;

	// Words loaded at the bottom of the sample store; every store size used stays within it.
	localparam int FILL_WORDS = 256;

	logic        clk;
	logic        arst_n;
	logic        cfg_write_en;
	logic [16:0] cfg_write_data;
	int          fail_count;
	int          pending;
	int          burst_left;
	int          beat_count;
	int          tick_count;
	int          stall_cycle;

	spm_in_if  in_ch ();
	spm_out_if out_ch ();

	pcm_sample_voice_mixer_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_ch          (in_ch),
		.out_ch         (out_ch),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data)
	);

	spm_mixer_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_mon         (in_ch),
		.out_mon        (out_ch),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	always #2 clk = ~clk;

	// The result side stalls on a pattern that rotates through always ready, random, mostly stalled and a periodic toggle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_cycle <= 0;
		end else begin
			stall_cycle <= stall_cycle + 1;
			case ((stall_cycle / 300) % 4)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= 1'($urandom_range(0, 1));
				2: out_ch.ready <= ($urandom_range(0, 3) == 0);
				default: out_ch.ready <= stall_cycle[2];
			endcase
		end
	end

	// Present one beat, with a random gap first when a paced burst has run out.
	task automatic send_beat(input spm_pkg::cmd_code_t cmd, input logic [10:0] off,
		input logic [15:0] d, input logic [15:0] addr, input bit paced);
		int gap;
		if (paced && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.reg_offset <= off;
		in_ch.write_data <= d;
		in_ch.mem_address <= addr;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		beat_count++;
		if (cmd == spm_pkg::CMD_TICK) begin
			tick_count++;
		end
	endtask

	task automatic voice_write(input logic [4:0] v, input logic [4:0] vreg, input logic [15:0] d);
		send_beat(spm_pkg::CMD_REG_WRITE, {1'b1, v, vreg}, d, 16'($urandom), 1'b1);
	endtask

	task automatic key_write(input logic [4:0] v, input logic [1:0] ctl);
		send_beat(spm_pkg::CMD_REG_WRITE, 11'(spm_pkg::OFF_VOICE_CTL), {9'h0, ctl, v}, 16'h0,
			1'b1);
	endtask

	task automatic tick();
		send_beat(spm_pkg::CMD_TICK, 11'($urandom), 16'($urandom), 16'($urandom), 1'b1);
	endtask

	// Let every expected result drain and the tick sequencer finish.
	task automatic drain();
		in_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (140) @(posedge clk);
	endtask

	task automatic set_mem_limit(input logic [16:0] words);
		cfg_write_en <= 1'b1;
		cfg_write_data <= words;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// One random beat, mostly shaped so that voices actually sound.
	task automatic random_beat();
		int pick;
		logic [4:0] v;
		logic [4:0] vreg;
		logic [15:0] d;
		logic [1:0] ctl;
		pick = $urandom_range(0, 99);
		v = 5'($urandom);
		d = 16'($urandom);
		if (pick < 40) begin
			tick();
		end else if (pick < 62) begin
			case ($urandom_range(0, 8))
				0: vreg = spm_pkg::VREG_START_HIGH;
				1: vreg = spm_pkg::VREG_START_LOW;
				2: vreg = spm_pkg::VREG_FREQ;
				3: vreg = spm_pkg::VREG_END_LOW;
				4: vreg = spm_pkg::VREG_END_LOOP;
				5: vreg = spm_pkg::VREG_LOOP_LOW;
				6: vreg = spm_pkg::VREG_PAN;
				7: vreg = spm_pkg::VREG_VOL_TYPE;
				default: vreg = spm_pkg::VREG_FLAG;
			endcase
			// Keep addresses near the bottom most of the time.
			if ($urandom_range(0, 3) != 0) begin
				if (vreg == spm_pkg::VREG_START_HIGH || vreg == spm_pkg::VREG_END_LOOP) begin
					d = 16'h0000;
				end else if (vreg == spm_pkg::VREG_START_LOW || vreg == spm_pkg::VREG_LOOP_LOW) begin
					d = 16'($urandom_range(0, 600));
				end else if (vreg == spm_pkg::VREG_END_LOW) begin
					d = 16'($urandom_range(0, 1200));
				end
			end
			voice_write(v, vreg, d);
		end else if (pick < 72) begin
			case ($urandom_range(0, 3))
				0: ctl = spm_pkg::KEYCTL_ON;
				1: ctl = spm_pkg::KEYCTL_REL;
				2: ctl = 2'b00;
				default: ctl = 2'b01;
			endcase
			ctl = ($urandom_range(0, 2) == 0) ? ctl : spm_pkg::KEYCTL_ON;
			send_beat(spm_pkg::CMD_REG_WRITE, 11'(spm_pkg::OFF_VOICE_CTL), {d[15:7], ctl, v},
				16'h0, 1'b1);
		end else if (pick < 82) begin
			send_beat(spm_pkg::CMD_REG_READ,
				$urandom_range(0, 1) ? 11'(spm_pkg::OFF_STATUS) : 11'($urandom),
				d, 16'($urandom), 1'b1);
		end else if (pick < 92) begin
			send_beat(spm_pkg::CMD_MEM_WRITE, 11'($urandom), d, 16'($urandom), 1'b1);
		end else begin
			send_beat(spm_pkg::CMD_REG_WRITE, 11'($urandom), d, 16'($urandom), 1'b1);
		end
	endtask

	initial begin
		logic [16:0] limits [6];
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_write_data = 17'h0;
		in_ch.valid = 1'b0;
		in_ch.command = spm_pkg::CMD_REG_WRITE;
		in_ch.reg_offset = 11'h0;
		in_ch.write_data = 16'h0;
		in_ch.mem_address = 16'h0;
		burst_left = 0;
		beat_count = 0;
		tick_count = 0;
		limits = '{17'd256, 17'd1, 17'd200, 17'd100, 17'd255, 17'd256};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Fill the bottom of the sample store; a voice only uses samples below the store size.
		for (int a = 0; a < FILL_WORDS; a++) begin
			send_beat(spm_pkg::CMD_MEM_WRITE, 11'($urandom), 16'($urandom), 16'(a), 1'b0);
		end
		drain();
		set_mem_limit(17'(FILL_WORDS));

		// Status register and reads at the corners of the offset range.
		send_beat(spm_pkg::CMD_REG_WRITE, 11'(spm_pkg::OFF_STATUS), 16'hFFFF, 16'h0, 1'b1);
		send_beat(spm_pkg::CMD_REG_READ, 11'(spm_pkg::OFF_STATUS), 16'h0, 16'h0, 1'b1);
		send_beat(spm_pkg::CMD_REG_READ, 11'h7FF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_beat(spm_pkg::CMD_REG_READ, 11'(spm_pkg::OFF_VOICE_CTL), 16'h0, 16'h0, 1'b1);
		// Voice 0: full-word format, loudest volume, full left and right, largest step.
		voice_write(5'd0, spm_pkg::VREG_START_LOW, 16'd16);
		voice_write(5'd0, spm_pkg::VREG_FREQ, 16'hFFFF);
		voice_write(5'd0, spm_pkg::VREG_END_LOW, 16'd40);
		voice_write(5'd0, spm_pkg::VREG_LOOP_LOW, 16'd8);
		key_write(5'd0, spm_pkg::KEYCTL_ON);
		tick();
		tick();
		tick();
		// Voice 31: low-byte format, pan index at and just below the cutoff, far end address.
		voice_write(5'd31, spm_pkg::VREG_PAN, {8'd100, 8'd99});
		voice_write(5'd31, spm_pkg::VREG_VOL_TYPE, 16'h40FF);
		voice_write(5'd31, spm_pkg::VREG_FREQ, 16'h0800);
		voice_write(5'd31, spm_pkg::VREG_END_LOW, 16'hFFFF);
		voice_write(5'd31, spm_pkg::VREG_END_LOOP, 16'h00FF);
		key_write(5'd31, spm_pkg::KEYCTL_ON);
		tick();
		// Voice 5: high-byte format, released with and without the timbre flag.
		voice_write(5'd5, spm_pkg::VREG_VOL_TYPE, 16'h8010);
		key_write(5'd5, spm_pkg::KEYCTL_ON);
		key_write(5'd5, spm_pkg::KEYCTL_REL);
		tick();
		voice_write(5'd5, spm_pkg::VREG_FLAG, 16'h0400);
		tick();
		// Zero-sample format, key off, and writes to unused offsets.
		voice_write(5'd31, spm_pkg::VREG_VOL_TYPE, 16'hC000);
		key_write(5'd0, 2'b00);
		send_beat(spm_pkg::CMD_REG_WRITE, 11'h407, 16'hFFFF, 16'h0, 1'b1);
		send_beat(spm_pkg::CMD_REG_WRITE, 11'h002, 16'hFFFF, 16'h0, 1'b1);
		tick();
		drain();

		// Random traffic under a range of sample store sizes.
		foreach (limits[p]) begin
			set_mem_limit(limits[p]);
			repeat (220) random_beat();
			drain();
		end

		$display("Run covered %0d beats with %0d output ticks over %0d sample store sizes.",
			beat_count, tick_count, $size(limits));
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
